// File: rtl/dtpp_pkg.sv
// Shared types and constants for the date text parser.
// Beat structs, field phase codes, limits and the month length table.
// No dependencies.
package dtpp_pkg;

    localparam logic [7:0]  ASCII_ZERO = 8'd48;
    localparam logic [7:0]  ASCII_NINE = 8'd57;
    localparam logic [7:0]  ASCII_DASH = 8'd45;

    localparam logic [13:0] YEAR_MAX   = 14'd8000;
    localparam logic [13:0] YEAR_SAT   = 14'd8001;
    localparam logic [3:0]  MONTH_SAT  = 4'd13;
    localparam logic [5:0]  DAY_SAT    = 6'd32;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [5:0]  DAY_LEAP   = 6'd29;

    localparam logic [8:0]  YEAR_SLOT  = 9'd372;
    localparam logic [4:0]  MONTH_SLOT = 5'd31;

    localparam int unsigned DATE_W = 22;
    localparam logic [DATE_W-1:0] DATE_MAX = 22'd2976371;

    typedef enum logic [1:0] {
        PH_YEAR  = 2'd0,
        PH_MONTH = 2'd1,
        PH_DAY   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic              valid_res;
        logic [DATE_W-1:0] date_value;
    } t_out_beat;

    // Fields of one finished date text, held for the check stage
    typedef struct packed {
        t_phase      phase;
        logic        bad;
        logic [13:0] year;
        logic [3:0]  month;
        logic [5:0]  day;
        logic [3:0]  yd3;
        logic [3:0]  yd2;
        logic [3:0]  yd1;
        logic [3:0]  yd0;
    } t_chk;

    function automatic logic [5:0] month_len(input logic [3:0] month);
        logic [5:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 6'd30;
            4'd2:                                        len = 6'd29;
            default:                                     len = 6'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/date_text_parse_pack.sv
// Top level of the streaming year-month-day date parser.
// Depends on dtpp_pkg for beat structs, phase codes and limits.
//
// Takes one character beat per cycle, with no gaps needed, unless stalled. Each
// accepted beat updates the year, month or day accumulator of its field.
// The beat marked last is captured into a check register; once the output
// register is free, the range, month length and leap year checks and the
// packed value year*372 + (month-1)*31 + (day-1) land in the output register.
// The input keeps accepting while a result waits, and stalls only when both
// the check and output registers are full and i_out_ready is low.
module date_text_parse_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dtpp_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dtpp_pkg::t_out_beat o_out_data
);
    import dtpp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_bad, n_bad;
    logic [13:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [5:0]  r_day, n_day;
    logic [3:0]  r_yd3, r_yd2, r_yd1, r_yd0;
    logic [3:0]  n_yd3, n_yd2, n_yd1, n_yd0;

    logic        r_chk_valid;
    t_chk        r_chk, n_chk;
    logic        r_out_valid;
    t_out_beat   r_out, n_out;

    logic        out_free;
    logic        chk_move;
    logic        in_acc;
    logic        is_dash;
    logic        is_digit;
    logic [3:0]  digit;
    logic [16:0] year_mul;
    logic [7:0]  month_mul;
    logic [8:0]  day_mul;

    logic        leap;
    logic        ok;
    logic [1:0]  lo_mod4;
    logic [1:0]  hi_mod4;
    logic [DATE_W-1:0] year_part;
    logic [DATE_W-1:0] month_part;
    logic [DATE_W-1:0] day_part;

    assign out_free   = !r_out_valid || i_out_ready;
    assign chk_move   = r_chk_valid && out_free;
    assign o_in_ready = !r_chk_valid || out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign is_dash  = (i_in_data.ch == ASCII_DASH);
    assign is_digit = (i_in_data.ch >= ASCII_ZERO) && (i_in_data.ch <= ASCII_NINE);
    assign digit    = 4'(i_in_data.ch - ASCII_ZERO);

    assign year_mul  = 17'({r_year, 3'b000}) + 17'({r_year, 1'b0}) + 17'(digit);
    assign month_mul = 8'({r_month, 3'b000}) + 8'({r_month, 1'b0}) + 8'(digit);
    assign day_mul   = 9'({r_day, 3'b000}) + 9'({r_day, 1'b0}) + 9'(digit);

    // Absorb one character
    always_comb begin
        n_phase = r_phase;
        n_bad   = r_bad;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_yd3   = r_yd3;
        n_yd2   = r_yd2;
        n_yd1   = r_yd1;
        n_yd0   = r_yd0;
        if (is_dash) begin
            unique case (r_phase)
                PH_YEAR:  n_phase = PH_MONTH;
                PH_MONTH: n_phase = PH_DAY;
                default:  n_bad   = 1'b1;
            endcase
        end else if (is_digit) begin
            unique case (r_phase)
                PH_YEAR: begin
                    n_year = (year_mul > 17'(YEAR_SAT)) ? YEAR_SAT : year_mul[13:0];
                    n_yd3  = r_yd2;
                    n_yd2  = r_yd1;
                    n_yd1  = r_yd0;
                    n_yd0  = digit;
                end
                PH_MONTH: begin
                    n_month = (month_mul > 8'(MONTH_SAT)) ? MONTH_SAT : month_mul[3:0];
                end
                default: begin
                    n_day = (day_mul > 9'(DAY_SAT)) ? DAY_SAT : day_mul[5:0];
                end
            endcase
        end else begin
            n_bad = 1'b1;
        end
    end

    always_comb begin
        n_chk.phase = n_phase;
        n_chk.bad   = n_bad;
        n_chk.year  = n_year;
        n_chk.month = n_month;
        n_chk.day   = n_day;
        n_chk.yd3   = n_yd3;
        n_chk.yd2   = n_yd2;
        n_chk.yd1   = n_yd1;
        n_chk.yd0   = n_yd0;
    end

    // Below the saturation point the year equals its last four digits
    assign lo_mod4 = 2'({r_chk.yd1[0], 1'b0}) + r_chk.yd0[1:0];
    assign hi_mod4 = 2'({r_chk.yd3[0], 1'b0}) + r_chk.yd2[1:0];
    always_comb begin
        if ((r_chk.yd1 == 4'd0) && (r_chk.yd0 == 4'd0)) begin
            leap = (hi_mod4 == 2'd0);
        end else begin
            leap = (lo_mod4 == 2'd0);
        end
    end

    always_comb begin
        ok = !r_chk.bad && (r_chk.phase == PH_DAY)
             && (r_chk.year <= YEAR_MAX)
             && (r_chk.month >= 4'd1) && (r_chk.month <= MONTH_LAST)
             && (r_chk.day >= 6'd1) && (r_chk.day <= month_len(r_chk.month))
             && !(!leap && (r_chk.month == MONTH_FEB) && (r_chk.day == DAY_LEAP));
    end

    assign year_part  = DATE_W'(r_chk.year[12:0]) * DATE_W'(YEAR_SLOT);
    assign month_part = DATE_W'(r_chk.month - 4'd1) * DATE_W'(MONTH_SLOT);
    assign day_part   = DATE_W'(r_chk.day - 6'd1);

    always_comb begin
        n_out.valid_res  = ok;
        n_out.date_value = ok ? (year_part + month_part + day_part) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_YEAR;
            r_bad   <= 1'b0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_yd3   <= '0;
            r_yd2   <= '0;
            r_yd1   <= '0;
            r_yd0   <= '0;
        end else if (in_acc) begin
            if (i_in_data.last) begin
                r_phase <= PH_YEAR;
                r_bad   <= 1'b0;
                r_year  <= '0;
                r_month <= '0;
                r_day   <= '0;
                r_yd3   <= '0;
                r_yd2   <= '0;
                r_yd1   <= '0;
                r_yd0   <= '0;
            end else begin
                r_phase <= n_phase;
                r_bad   <= n_bad;
                r_year  <= n_year;
                r_month <= n_month;
                r_day   <= n_day;
                r_yd3   <= n_yd3;
                r_yd2   <= n_yd2;
                r_yd1   <= n_yd1;
                r_yd0   <= n_yd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && i_in_data.last) begin
                r_chk_valid <= 1'b1;
            end else if (chk_move) begin
                r_chk_valid <= 1'b0;
            end
            if (chk_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last) begin
            r_chk <= n_chk;
        end
        if (chk_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.valid_res |-> o_out_data.date_value == '0)
        else $error("invalid result carries a non-zero date value");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res |-> o_out_data.date_value <= DATE_MAX)
        else $error("packed date out of range");

    a_last_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last |=> r_chk_valid)
        else $error("last beat not captured for checking");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last |=> r_phase == PH_YEAR && !r_bad && r_year == '0
                                     && r_month == '0 && r_day == '0)
        else $error("parser state not cleared after last beat");

    a_chk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid && !out_free |=> r_chk_valid && $stable(r_chk))
        else $error("check register lost while output stalled");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for date_text_parse_pack: streams date texts a character per beat,
// predicts each packed result and checks it. Depends on dtpp_pkg for beat types.
module tb;
    import dtpp_pkg::*;

    localparam int unsigned CH_ZERO = 48;
    localparam int unsigned CH_NINE = 57;
    localparam int unsigned CH_DASH = 45;
    localparam int unsigned YEAR_TOP = 8000;
    localparam int unsigned YEAR_CAP = 8001;
    localparam int unsigned MON_CAP = 13;
    localparam int unsigned DAY_CAP = 32;
    localparam int unsigned MDAYS [16] = '{0, 31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31,
                                           0, 0, 0};
    localparam int RANDOM_BEATS = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF = 400;
    localparam int DRAIN = 8;

    localparam t_out_beat NO_DATE = '0;
    localparam t_out_beat DAY_ZERO = {1'b1, 22'd0};
    localparam t_out_beat DAY_TOP = {1'b1, 22'd2976371};

    typedef struct packed {
        t_in_beat  b;
        logic      fixed;
        t_out_beat want;
    } t_stim;

    typedef struct {
        string      txt;
        logic [7:0] raw;
        logic       fixed;
        t_out_beat  want;
    } t_row;

    logic      i_clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_stim     cur = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_data;

    t_stim     stim_q[$];
    t_out_beat date_q[$];

    t_phase      ph = PH_YEAR;
    logic [13:0] yr = '0;
    logic [3:0]  mo = '0;
    logic [5:0]  dy = '0;
    logic        bad = 1'b0;

    int n_err = 0;
    int n_beats = 0;
    int n_dates = 0;
    int quiet = 0;

    date_text_parse_pack uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (cur.b),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned acc10(int unsigned acc, int unsigned d, int unsigned cap);
        int unsigned v;
        v = acc * 10 + d;
        return (v > cap) ? cap : v;
    endfunction

    function automatic t_out_beat parse_char(t_in_beat b);
        t_out_beat   r;
        int unsigned v;
        logic        leap;
        logic        ok;
        r = NO_DATE;
        if (b.ch == CH_DASH) begin
            if (ph == PH_YEAR) ph = PH_MONTH;
            else if (ph == PH_MONTH) ph = PH_DAY;
            else bad = 1'b1;
        end else if (b.ch >= CH_ZERO && b.ch <= CH_NINE) begin
            case (ph)
                PH_YEAR:  yr = 14'(acc10(yr, b.ch - CH_ZERO, YEAR_CAP));
                PH_MONTH: mo = 4'(acc10(mo, b.ch - CH_ZERO, MON_CAP));
                default:  dy = 6'(acc10(dy, b.ch - CH_ZERO, DAY_CAP));
            endcase
        end else begin
            bad = 1'b1;
        end
        if (b.last) begin
            leap = (yr % 400 == 0) || (yr % 100 != 0 && yr % 4 == 0);
            ok = !bad && ph == PH_DAY && yr <= YEAR_TOP && mo >= 1 && mo <= 12
                 && dy >= 1 && dy <= MDAYS[mo] && !(!leap && mo == 2 && dy == 29);
            if (ok) begin
                v = yr;
                v = v * 372 + (mo - 1) * 31 + dy - 1;
                r.valid_res = 1'b1;
                r.date_value = v[21:0];
            end
            ph = PH_YEAR;
            yr = '0;
            mo = '0;
            dy = '0;
            bad = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        n_err++;
    endtask

    task automatic add_beat(logic [7:0] ch, logic last, logic fixed, t_out_beat want);
        t_stim s;
        s.b.ch = ch;
        s.b.last = last;
        s.fixed = fixed;
        s.want = want;
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic add_text(string txt, logic fixed, t_out_beat want);
        for (int i = 0; i < txt.len(); i++)
            add_beat(txt.getc(i), i == txt.len() - 1, fixed && i == txt.len() - 1, want);
    endtask

    // Predict on every accepted character, check every accepted result
    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat pred;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                n_beats++;
                pred = parse_char(cur.b);
                if (cur.b.last) date_q.insert(date_q.size(), cur.fixed ? cur.want : pred);
            end
            if (out_valid && out_ready) begin
                got = out_data;
                n_dates++;
                if (date_q.size() == 0) begin
                    report_mismatch("result with no date pending", 32'(got.date_value), 0);
                end else begin
                    pred = date_q.pop_front();
                    if (got.valid_res !== pred.valid_res)
                        report_mismatch("valid_res", 32'(got.valid_res),
                                        32'(pred.valid_res));
                    if (got.date_value !== pred.date_value)
                        report_mismatch("date_value", 32'(got.date_value),
                                        32'(pred.date_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) quiet++;
        else quiet = 0;
        if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : take_results
        int  hold;
        int  taken;
        logic gaps_on;
        taken = 0;
        gaps_on = 1'b1;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (taken % 16 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (taken == 30) hold = HOLD_OFF;
            else hold = gaps_on ? $urandom_range(0, 11) : 0;
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : drive_chars
        t_row        rows [13];
        int          n_dir;
        int          gap;
        int          pick;
        int          n;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        string       ys;
        string       ms;
        string       ds;
        string       sep1;
        string       sep2;
        string       txt;
        logic        gaps_on;
        int unsigned years [10] = '{0, 4, 100, 400, 1900, 2000, 2024, 7999, 8000, 8001};

        rows = '{
            '{"-1-1",       8'h00, 1'b1, DAY_ZERO},
            '{"8000-12-31", 8'h00, 1'b1, DAY_TOP},
            '{"",           8'h00, 1'b1, NO_DATE},
            '{"",           8'hff, 1'b1, NO_DATE},
            '{"--1-",       8'h00, 1'b1, NO_DATE},
            '{"1",          8'h00, 1'b1, NO_DATE},
            '{"--1",        8'h00, 1'b1, NO_DATE},
            '{"-1-",        8'h00, 1'b1, NO_DATE},
            '{"-1-a",       8'h00, 1'b1, NO_DATE},
            '{"100-2-29",   8'h00, 1'b1, NO_DATE},
            '{"-2-29",      8'h00, 1'b0, NO_DATE},
            '{"-1-999",     8'h00, 1'b1, NO_DATE},
            '{"-4-31",      8'h00, 1'b1, NO_DATE}
        };
        foreach (rows[i]) begin
            if (rows[i].txt.len() == 0) add_beat(rows[i].raw, 1'b1, rows[i].fixed, rows[i].want);
            else add_text(rows[i].txt, rows[i].fixed, rows[i].want);
        end
        n_dir = stim_q.size();

        while (stim_q.size() < n_dir + RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                    add_beat(8'($urandom_range(0, 255)),
                             j == n - 1 || $urandom_range(0, 3) == 0, 1'b0, NO_DATE);
            end else begin
                case ($urandom_range(0, 3))
                    0: y = years[$urandom_range(0, 9)];
                    1: y = $urandom_range(0, 99);
                    2: y = ($urandom_range(0, 3) == 0) ? $urandom_range(8001, 99999)
                                                       : $urandom_range(0, 8001);
                    default: y = $urandom_range(0, 8001);
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    m = 2;
                    d = $urandom_range(27, 30);
                end else if ($urandom_range(0, 9) == 0) begin
                    m = $urandom_range(0, 99);
                    d = $urandom_range(0, 99);
                end else begin
                    m = $urandom_range(1, 12);
                    d = $urandom_range(1, MDAYS[m] + 1);
                end
                if (pick < 5) begin
                    ys = $sformatf("%0d", y);
                    ms = $sformatf("%0d", m);
                    ds = $sformatf("%0d", d);
                end else begin
                    ys = $sformatf("%04d", y);
                    ms = $sformatf("%02d", m);
                    ds = $sformatf("%02d", d);
                end
                sep1 = "-";
                sep2 = "-";
                case ($urandom_range(0, 23))
                    0: ys = "";
                    1: ms = "";
                    2: ds = "";
                    3: sep1 = "";
                    4: sep2 = "";
                    5: sep2 = "--";
                    6: ds = {ds, "-"};
                    default: ;
                endcase
                txt = {ys, sep1, ms, sep2, ds};
                if (txt.len() == 0) txt = "0";
                if ($urandom_range(0, 11) == 0)
                    txt.putc($urandom_range(0, txt.len() - 1), 8'($urandom_range(1, 255)));
                add_text(txt, 1'b0, NO_DATE);
            end
        end

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        gaps_on = 1'b1;
        for (int k = 0; k < stim_q.size(); k++) begin
            if (k % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            gap = gaps_on ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            cur <= stim_q[k];
            do @(posedge i_clk); while (!in_ready);
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (date_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d character beats and %0d dates, directed edge cases first,",
                 n_beats, n_dates);
        $display("then random dates, noise and a long hold-off on the result side");
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_err);
            $display("FAIL");
        end
        $finish;
    end
endmodule
